// ----- rtl/dda_pkg.sv -----
package dda_pkg;

   // Default geometry: integer bits of a coordinate, fraction bits of a position
   localparam int DDA_COORD_BITS = 10;
   localparam int DDA_FRAC_BITS  = 16;

   // Request kinds carried on req_tuser
   localparam logic CMD_START   = 1'b0;
   localparam logic CMD_ADVANCE = 1'b1;

   // Microprogram address
   localparam int UPC_BITS = 3;
   typedef logic [UPC_BITS-1:0] upc_type;

   localparam upc_type UPC_FETCH    = 3'd0;
   localparam upc_type UPC_DISPATCH = 3'd1;
   localparam upc_type UPC_ADVANCE  = 3'd2;
   localparam upc_type UPC_SETUP    = 3'd3;
   localparam upc_type UPC_DIVIDE   = 3'd4;
   localparam upc_type UPC_FINISH   = 3'd5;

   // Datapath operation of one step
   typedef enum logic [2:0] {
      OP_NONE    = 3'd0,
      OP_ACCEPT  = 3'd1,
      OP_SETUP   = 3'd2,
      OP_DIVIDE  = 3'd3,
      OP_FINISH  = 3'd4,
      OP_ADVANCE = 3'd5
   } uop_type;

   // Pixel emission of one step
   typedef enum logic [1:0] {
      EMIT_NONE   = 2'd0,
      EMIT_ALWAYS = 2'd1,
      EMIT_ACTIVE = 2'd2
   } emit_type;

   // Jump condition of one step; when false the step counter advances
   typedef enum logic [2:0] {
      COND_NEXT       = 3'd0,
      COND_ALWAYS     = 3'd1,
      COND_NO_REQ     = 3'd2,
      COND_IS_START   = 3'd3,
      COND_STEPS_ZERO = 3'd4,
      COND_COUNT_NZ   = 3'd5
   } cond_type;

   typedef struct packed {
      uop_type  op;
      emit_type emit;
      cond_type cond;
      upc_type  target;
   } uword_type;

   // Control store
   function automatic uword_type ucode_rom(input upc_type addr);
      uword_type w;
      case (addr)
         UPC_FETCH:    w = '{op: OP_ACCEPT,  emit: EMIT_NONE,   cond: COND_NO_REQ,
                             target: UPC_FETCH};
         UPC_DISPATCH: w = '{op: OP_NONE,    emit: EMIT_NONE,   cond: COND_IS_START,
                             target: UPC_SETUP};
         UPC_ADVANCE:  w = '{op: OP_ADVANCE, emit: EMIT_ACTIVE, cond: COND_ALWAYS,
                             target: UPC_FETCH};
         UPC_SETUP:    w = '{op: OP_SETUP,   emit: EMIT_ALWAYS, cond: COND_STEPS_ZERO,
                             target: UPC_FETCH};
         UPC_DIVIDE:   w = '{op: OP_DIVIDE,  emit: EMIT_NONE,   cond: COND_COUNT_NZ,
                             target: UPC_DIVIDE};
         UPC_FINISH:   w = '{op: OP_FINISH,  emit: EMIT_NONE,   cond: COND_ALWAYS,
                             target: UPC_FETCH};
         default:      w = '{op: OP_NONE,    emit: EMIT_NONE,   cond: COND_ALWAYS,
                             target: UPC_FETCH};
      endcase
      return w;
   endfunction

endpackage

// ----- rtl/dda_line_rasterizer_unit.sv -----
// Channel | Dir | Handshake             | Payload
// req     | in  | req_tvalid/req_tready | tuser: command; tdata: x_start, y_start, x_end, y_end
// rsp     | out | rsp_tvalid/rsp_tready | tdata: pixel_x, pixel_y; tlast: last_pixel
//
// An advance request runs the microprogram states fetch, dispatch and pixel step.
// A start request runs fetch, dispatch, setup, FRAC_BITS + 1 restoring-division
// iterations (both axes in parallel), and the step sign fixup.
// A zero-length start ends after setup. Synchronous active-high reset returns the
// sequencer to fetch and drops any line in progress; no clearing pass is needed.
// A step that emits a pixel holds while the response register carries a pixel not taken.
module dda_line_rasterizer_unit
   import dda_pkg::*;
#(
   parameter int COORD_BITS = DDA_COORD_BITS,
   parameter int FRAC_BITS  = DDA_FRAC_BITS
) (
   input  logic clock,
   input  logic reset,

   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   // bits from 0: command
   input  logic                                  req_tuser,
   // bits from 0: x_start, y_start, x_end, y_end, zero fill
   input  logic [((4*COORD_BITS+7)/8)*8-1:0]     req_tdata,

   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   // bits from 0: pixel_x, pixel_y, zero fill
   output logic [((2*COORD_BITS+7)/8)*8-1:0]     rsp_tdata,
   output logic                                  rsp_tlast
);

   localparam int RSP_DATA_BITS = ((2*COORD_BITS+7)/8)*8;
   localparam int POS_BITS      = COORD_BITS + FRAC_BITS;
   localparam int STEP_BITS     = FRAC_BITS + 2;
   localparam int QUO_BITS      = FRAC_BITS + 1;
   localparam int REM_BITS      = COORD_BITS + 1;
   localparam int CNT_BITS      = $clog2(FRAC_BITS + 1);
   localparam logic [POS_BITS-1:0] HALF_POS = POS_BITS'(1) << (FRAC_BITS - 1);

   typedef logic [COORD_BITS-1:0] coord_type;
   typedef logic [POS_BITS-1:0]   pos_type;
   typedef logic [STEP_BITS-1:0]  step_type;
   typedef logic [QUO_BITS-1:0]   quo_type;
   typedef logic [REM_BITS-1:0]   rem_type;

   // Sequencer
   upc_type   upc_ff, upc_in;
   uword_type uw;
   logic      take_jump, emit_req, hold, exec, accept;

   // Latched request
   logic      cmd_ff, cmd_in;
   coord_type x0_ff, x0_in, y0_ff, y0_in, x1_ff, x1_in, y1_ff, y1_in;

   // Line state
   pos_type   pos_x_ff, pos_x_in, pos_y_ff, pos_y_in;
   step_type  step_x_ff, step_x_in, step_y_ff, step_y_in;
   coord_type steps_left_ff, steps_left_in;
   logic      active_ff, active_in;

   // Divider
   coord_type divisor_ff, divisor_in;
   rem_type   rem_x_ff, rem_x_in, rem_y_ff, rem_y_in;
   quo_type   quo_x_ff, quo_x_in, quo_y_ff, quo_y_in;
   logic      neg_x_ff, neg_x_in, neg_y_ff, neg_y_in;
   logic [CNT_BITS-1:0] count_ff, count_in;

   // Response register
   logic      rsp_valid_ff, rsp_valid_in;
   coord_type pix_x_ff, pix_x_in, pix_y_ff, pix_y_in;
   logic      last_ff, last_in;

   // Setup and step arithmetic
   logic [COORD_BITS:0] dx, dy;
   coord_type adx, ady, steps;
   logic      ge_x, ge_y;
   rem_type   div_rem_x, div_rem_y;
   pos_type   next_pos_x, next_pos_y, rnd_x, rnd_y;
   step_type  mag_x, mag_y;

   // Decode the current control word
   always_comb begin
      uw         = ucode_rom(upc_ff);
      req_tready = (uw.op == OP_ACCEPT);
      accept     = req_tvalid && req_tready;
      case (uw.emit)
         EMIT_ALWAYS: emit_req = 1'b1;
         EMIT_ACTIVE: emit_req = active_ff;
         default:     emit_req = 1'b0;
      endcase
      hold = emit_req && rsp_valid_ff && !rsp_tready;
      exec = !hold;
   end

   // Endpoint deltas and step count
   always_comb begin
      dx    = {1'b0, x1_ff} - {1'b0, x0_ff};
      dy    = {1'b0, y1_ff} - {1'b0, y0_ff};
      adx   = dx[COORD_BITS] ? coord_type'(-dx) : dx[COORD_BITS-1:0];
      ady   = dy[COORD_BITS] ? coord_type'(-dy) : dy[COORD_BITS-1:0];
      steps = (ady > adx) ? ady : adx;
   end

   // Jump select
   always_comb begin
      case (uw.cond)
         COND_ALWAYS:     take_jump = 1'b1;
         COND_NO_REQ:     take_jump = !req_tvalid;
         COND_IS_START:   take_jump = (cmd_ff == CMD_START);
         COND_STEPS_ZERO: take_jump = (steps == '0);
         COND_COUNT_NZ:   take_jump = (count_ff != '0);
         default:         take_jump = 1'b0;
      endcase
      if (hold) begin
         upc_in = upc_ff;
      end else if (take_jump) begin
         upc_in = uw.target;
      end else begin
         upc_in = upc_ff + upc_type'(1);
      end
   end

   // One restoring-division bit per axis, and the pixel step
   always_comb begin
      ge_x       = (rem_x_ff >= {1'b0, divisor_ff});
      ge_y       = (rem_y_ff >= {1'b0, divisor_ff});
      div_rem_x  = (ge_x ? rem_x_ff - {1'b0, divisor_ff} : rem_x_ff) << 1;
      div_rem_y  = (ge_y ? rem_y_ff - {1'b0, divisor_ff} : rem_y_ff) << 1;
      mag_x      = {1'b0, quo_x_ff};
      mag_y      = {1'b0, quo_y_ff};
      next_pos_x = pos_x_ff + {{(POS_BITS-STEP_BITS){step_x_ff[STEP_BITS-1]}}, step_x_ff};
      next_pos_y = pos_y_ff + {{(POS_BITS-STEP_BITS){step_y_ff[STEP_BITS-1]}}, step_y_ff};
      rnd_x      = next_pos_x + HALF_POS;
      rnd_y      = next_pos_y + HALF_POS;
   end

   // Datapath next state
   always_comb begin
      cmd_in        = cmd_ff;
      x0_in         = x0_ff;
      y0_in         = y0_ff;
      x1_in         = x1_ff;
      y1_in         = y1_ff;
      pos_x_in      = pos_x_ff;
      pos_y_in      = pos_y_ff;
      step_x_in     = step_x_ff;
      step_y_in     = step_y_ff;
      steps_left_in = steps_left_ff;
      active_in     = active_ff;
      divisor_in    = divisor_ff;
      rem_x_in      = rem_x_ff;
      rem_y_in      = rem_y_ff;
      quo_x_in      = quo_x_ff;
      quo_y_in      = quo_y_ff;
      neg_x_in      = neg_x_ff;
      neg_y_in      = neg_y_ff;
      count_in      = count_ff;
      pix_x_in      = pix_x_ff;
      pix_y_in      = pix_y_ff;
      last_in       = last_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;

      if (exec) begin
         case (uw.op)
            OP_ACCEPT: begin
               if (accept) begin
                  cmd_in = req_tuser;
                  x0_in  = req_tdata[COORD_BITS-1:0];
                  y0_in  = req_tdata[2*COORD_BITS-1:COORD_BITS];
                  x1_in  = req_tdata[3*COORD_BITS-1:2*COORD_BITS];
                  y1_in  = req_tdata[4*COORD_BITS-1:3*COORD_BITS];
               end
            end
            OP_SETUP: begin
               pos_x_in      = {x0_ff, {FRAC_BITS{1'b0}}};
               pos_y_in      = {y0_ff, {FRAC_BITS{1'b0}}};
               step_x_in     = '0;
               step_y_in     = '0;
               steps_left_in = steps;
               active_in     = (steps != '0);
               divisor_in    = steps;
               rem_x_in      = {1'b0, adx};
               rem_y_in      = {1'b0, ady};
               quo_x_in      = '0;
               quo_y_in      = '0;
               neg_x_in      = dx[COORD_BITS];
               neg_y_in      = dy[COORD_BITS];
               count_in      = CNT_BITS'(FRAC_BITS);
               pix_x_in      = x0_ff;
               pix_y_in      = y0_ff;
               last_in       = (steps == '0);
               rsp_valid_in  = 1'b1;
            end
            OP_DIVIDE: begin
               rem_x_in = div_rem_x;
               rem_y_in = div_rem_y;
               quo_x_in = {quo_x_ff[QUO_BITS-2:0], ge_x};
               quo_y_in = {quo_y_ff[QUO_BITS-2:0], ge_y};
               count_in = count_ff - CNT_BITS'(1);
            end
            OP_FINISH: begin
               step_x_in = neg_x_ff ? -mag_x : mag_x;
               step_y_in = neg_y_ff ? -mag_y : mag_y;
            end
            OP_ADVANCE: begin
               if (active_ff) begin
                  pos_x_in      = next_pos_x;
                  pos_y_in      = next_pos_y;
                  steps_left_in = steps_left_ff - coord_type'(1);
                  active_in     = (steps_left_ff != coord_type'(1));
                  pix_x_in      = rnd_x[POS_BITS-1:FRAC_BITS];
                  pix_y_in      = rnd_y[POS_BITS-1:FRAC_BITS];
                  last_in       = (steps_left_ff == coord_type'(1));
                  rsp_valid_in  = 1'b1;
               end
            end
            default: begin
            end
         endcase
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         upc_ff       <= UPC_FETCH;
         active_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         upc_ff       <= upc_in;
         active_ff    <= active_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      cmd_ff        <= cmd_in;
      x0_ff         <= x0_in;
      y0_ff         <= y0_in;
      x1_ff         <= x1_in;
      y1_ff         <= y1_in;
      pos_x_ff      <= pos_x_in;
      pos_y_ff      <= pos_y_in;
      step_x_ff     <= step_x_in;
      step_y_ff     <= step_y_in;
      steps_left_ff <= steps_left_in;
      divisor_ff    <= divisor_in;
      rem_x_ff      <= rem_x_in;
      rem_y_ff      <= rem_y_in;
      quo_x_ff      <= quo_x_in;
      quo_y_ff      <= quo_y_in;
      neg_x_ff      <= neg_x_in;
      neg_y_ff      <= neg_y_in;
      count_ff      <= count_in;
      pix_x_ff      <= pix_x_in;
      pix_y_ff      <= pix_y_in;
      last_ff       <= last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_DATA_BITS'({pix_y_ff, pix_x_ff});
   assign rsp_tlast  = last_ff;

   // An accepted request always moves the sequencer on to dispatch
   a_accept_dispatch: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> (upc_ff == UPC_DISPATCH))
      else $error("accepted request did not reach dispatch");

   // A live line always has advances left
   a_active_steps: assert property (@(posedge clock) disable iff (reset)
      active_ff |-> (steps_left_ff != '0))
      else $error("line active with no steps left");

   // Partial remainders stay below twice the divisor
   a_rem_bound: assert property (@(posedge clock) disable iff (reset)
      (upc_ff == UPC_DIVIDE) |->
         ((rem_x_ff < {divisor_ff, 1'b0}) && (rem_y_ff < {divisor_ff, 1'b0})))
      else $error("division remainder out of range");

endmodule

// ----- bench/dda_line_rasterizer_unit_tb.sv -----
module dda_line_rasterizer_unit_tb
   import dda_pkg::*;
();

   localparam int CB              = DDA_COORD_BITS;
   localparam int FB              = DDA_FRAC_BITS;
   localparam int POS_W           = CB + FB;
   localparam int STEP_W          = FB + 2;
   localparam int REQ_W           = ((4*CB+7)/8)*8;
   localparam int RSP_W           = ((2*CB+7)/8)*8;
   localparam int COORD_MAX       = (1 << CB) - 1;
   localparam int QUIET_LIMIT     = 4000;
   localparam int SETTLE_CYCLES   = 4*(FB+5);
   localparam int ITEMS_PER_PHASE = 500;
   localparam int REPORT_LIMIT    = 10;

   localparam logic [CB-1:0] SCREEN_MIN = '0;
   localparam logic [CB-1:0] SCREEN_MAX = CB'(COORD_MAX);

   typedef struct packed {
      logic [CB-1:0] px;
      logic [CB-1:0] py;
      logic          last_pixel;
   } pixel_type;

   logic             clock      = 1'b0;
   logic             reset      = 1'b1;
   logic             req_tvalid = 1'b0;
   logic             req_tready;
   // bits from 0: command
   logic             req_tuser  = 1'b0;
   // bits from 0: x_start, y_start, x_end, y_end, zero fill
   logic [REQ_W-1:0] req_tdata  = '0;
   logic             rsp_tvalid;
   logic             rsp_tready = 1'b0;
   // bits from 0: pixel_x, pixel_y, zero fill
   logic [RSP_W-1:0] rsp_tdata;
   logic             rsp_tlast;

   // Line state of the predictor, zero after reset
   logic [POS_W-1:0]  line_pos_x      = '0;
   logic [POS_W-1:0]  line_pos_y      = '0;
   logic [STEP_W-1:0] line_step_x     = '0;
   logic [STEP_W-1:0] line_step_y     = '0;
   logic [CB-1:0]     line_steps_left = '0;
   logic              line_live       = 1'b0;

   pixel_type expected_pixels[$];
   int     useful_items   = 0;
   int     mismatch_count = 0;
   int     pixels_seen    = 0;
   int     send_idle_pct  = 0;
   int     recv_idle_pct  = 0;

   dda_line_rasterizer_unit uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   // Round a fixed-point position to the nearest pixel
   function automatic logic [CB-1:0] round_coord(input logic [POS_W-1:0] pos);
      logic [POS_W:0] sum;
      sum = {1'b0, pos} + (POS_W+1)'(1 << (FB-1));
      return sum[FB+CB-1:FB];
   endfunction

   // Per-pixel increment: (delta << FB) / steps, truncated toward zero
   function automatic logic [STEP_W-1:0] axis_step(input int delta, input int steps);
      longint mag;
      longint quo;
      mag = (delta < 0) ? -delta : delta;
      quo = (mag << FB) / steps;
      if (delta < 0)
         quo = -quo;
      return quo[STEP_W-1:0];
   endfunction

   // Advance the predicted line state by one request, queue any pixel it emits
   function automatic void predict_pixel(input logic cmd,
                                         input logic [CB-1:0] xs, ys, xe, ye);
      int dx, dy, adx, ady, steps;
      if (cmd == CMD_START) begin
         dx    = int'(xe) - int'(xs);
         dy    = int'(ye) - int'(ys);
         adx   = (dx < 0) ? -dx : dx;
         ady   = (dy < 0) ? -dy : dy;
         steps = (ady > adx) ? ady : adx;
         line_pos_x      = POS_W'(xs) << FB;
         line_pos_y      = POS_W'(ys) << FB;
         line_step_x     = (steps != 0) ? axis_step(dx, steps) : '0;
         line_step_y     = (steps != 0) ? axis_step(dy, steps) : '0;
         line_steps_left = steps[CB-1:0];
         line_live       = (steps != 0);
      end else if (line_live) begin
         line_pos_x = line_pos_x + {{(POS_W-STEP_W){line_step_x[STEP_W-1]}}, line_step_x};
         line_pos_y = line_pos_y + {{(POS_W-STEP_W){line_step_y[STEP_W-1]}}, line_step_y};
         line_steps_left = line_steps_left - 1'b1;
         if (line_steps_left == '0)
            line_live = 1'b0;
      end else begin
         // advance with no line in progress: nothing comes out
         return;
      end
      useful_items++;
      expected_pixels.push_back('{px: round_coord(line_pos_x), py: round_coord(line_pos_y),
                                  last_pixel: !line_live});
   endfunction

   function automatic logic [CB-1:0] rand_coord();
      return CB'($urandom_range(COORD_MAX));
   endfunction

   // Pick a coordinate up to 12 pixels away, clamped to the screen
   function automatic logic [CB-1:0] near_coord(input logic [CB-1:0] c);
      int t;
      t = int'(c) + int'($urandom_range(24)) - 12;
      if (t < 0)
         t = 0;
      if (t > COORD_MAX)
         t = COORD_MAX;
      return t[CB-1:0];
   endfunction

   task automatic note_failure(input string msg);
      mismatch_count++;
      if (mismatch_count <= REPORT_LIMIT)
         $display("%s", msg);
   endtask

   // Send one request after a random gap; valid stays high for the next call
   task automatic send_request(input logic cmd, input logic [CB-1:0] xs, ys, xe, ye);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= cmd;
      req_tdata  <= REQ_W'({ye, xe, ys, xs});
      do @(posedge clock); while (!req_tready);
      predict_pixel(cmd, xs, ys, xe, ye);
   endtask

   // Advance with junk endpoints, which the block must ignore
   task automatic send_advance();
      send_request(CMD_ADVANCE, rand_coord(), rand_coord(), rand_coord(), rand_coord());
   endtask

   // Start a line and walk it; extra < 0 cuts it short, extra > 0 overruns it
   task automatic send_line(input logic [CB-1:0] xs, ys, xe, ye, input int extra);
      int n;
      send_request(CMD_START, xs, ys, xe, ye);
      n = int'(line_steps_left) + extra;
      repeat ((n > 0) ? n : 0) send_advance();
   endtask

   // Hold off requests until every queued pixel has arrived
   task automatic wait_drained();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (expected_pixels.size() != 0);
   endtask

   // Advances with no line, and zero-length lines at both screen corners
   task automatic test_idle_commands();
      send_advance();
      send_request(CMD_START, SCREEN_MAX, SCREEN_MAX, SCREEN_MAX, SCREEN_MAX);
      send_advance();
      send_request(CMD_START, SCREEN_MIN, SCREEN_MIN, SCREEN_MIN, SCREEN_MIN);
      send_advance();
      wait_drained();
   endtask

   // Full-screen diagonals, each dropped by the next start
   task automatic test_restart();
      send_line(SCREEN_MIN, SCREEN_MIN, SCREEN_MAX, SCREEN_MAX, 2 - COORD_MAX);
      send_line(SCREEN_MAX, SCREEN_MIN, SCREEN_MIN, SCREEN_MAX, 1 - COORD_MAX);
      send_line(SCREEN_MIN, SCREEN_MAX, SCREEN_MAX, SCREEN_MIN, 1 - COORD_MAX);
      wait_drained();
   endtask

   // Steep, shallow and equal-slope lines walked to their end
   task automatic test_short_lines();
      send_line(SCREEN_MAX, SCREEN_MAX, SCREEN_MAX - CB'(2), SCREEN_MAX - CB'(7), 1);
      send_line(CB'(0), CB'(0), CB'(3), CB'(1), 0);
      send_line(CB'(5), CB'(9), CB'(2), CB'(6), 0);
      wait_drained();
   endtask

   // Mostly complete lines with random endpoints, some broken ones and noise
   task automatic test_random_traffic(input int sender_pct, input int receiver_pct);
      int goal, r, extra;
      logic [CB-1:0] xs, ys, xe, ye;
      send_idle_pct = sender_pct;
      recv_idle_pct = receiver_pct;
      goal = useful_items + ITEMS_PER_PHASE;
      while (useful_items < goal) begin
         if ($urandom_range(9) == 0) begin
            repeat ($urandom_range(1, 4))
               send_request(1'($urandom_range(1)), rand_coord(), rand_coord(),
                            rand_coord(), rand_coord());
         end else begin
            xs = rand_coord();
            ys = rand_coord();
            r  = $urandom_range(49);
            if (r == 0) begin
               xe = rand_coord();
               ye = rand_coord();
            end else if (r < 3) begin
               xe = xs;
               ye = ys;
            end else begin
               xe = near_coord(xs);
               ye = near_coord(ys);
            end
            r = $urandom_range(23);
            if (r < 4)
               extra = -int'($urandom_range(1, 6));
            else if (r < 7)
               extra = $urandom_range(1, 3);
            else
               extra = 0;
            send_line(xs, ys, xe, ye, extra);
         end
      end
      wait_drained();
   endtask

   // Compare each accepted pixel with the oldest prediction; drive ready at random
   always @(posedge clock) begin : rsp_check
      pixel_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         pixels_seen++;
         if (expected_pixels.size() == 0) begin
            note_failure($sformatf("pixel %0d: none expected, got x=%0d y=%0d last=%0b",
                                   pixels_seen, rsp_tdata[CB-1:0], rsp_tdata[2*CB-1:CB],
                                   rsp_tlast));
         end else begin
            want = expected_pixels.pop_front();
            if (rsp_tdata[CB-1:0] !== want.px)
               note_failure($sformatf("pixel %0d: pixel_x expected %0d, got %0d",
                                      pixels_seen, want.px, rsp_tdata[CB-1:0]));
            if (rsp_tdata[2*CB-1:CB] !== want.py)
               note_failure($sformatf("pixel %0d: pixel_y expected %0d, got %0d",
                                      pixels_seen, want.py, rsp_tdata[2*CB-1:CB]));
            if (rsp_tlast !== want.last_pixel)
               note_failure($sformatf("pixel %0d: last_pixel expected %0b, got %0b",
                                      pixels_seen, want.last_pixel, rsp_tlast));
         end
      end
      rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
   end

   // End the run when neither channel moves for too long
   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < QUIET_LIMIT) begin
         @(posedge clock);
         if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
            quiet = 0;
         else
            quiet++;
      end
      $display("== FAIL ==");
      $finish;
   end

   initial begin
      send_idle_pct = 24;
      recv_idle_pct = 58;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      test_idle_commands();
      test_restart();
      test_short_lines();
      test_random_traffic(24, 58);
      test_random_traffic(58, 24);
      test_random_traffic(0, 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && expected_pixels.size() == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

endmodule
